// ----- rtl/cell_to_node_weighted_average_defines.svh -----
// assertion macros used by the checker file
`ifndef CELL_TO_NODE_WEIGHTED_AVERAGE_DEFINES_SVH
`define CELL_TO_NODE_WEIGHTED_AVERAGE_DEFINES_SVH

// same-cycle implication, held off during reset
`define CTNWA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctnwa check failed");

// next-cycle implication, held off during reset
`define CTNWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctnwa check failed");

`endif

// ----- rtl/ctnwa_pkg.sv -----
// types and constants of the cell-to-node weighted average block
`default_nettype none
package ctnwa_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_ADJACENT = 16;
  localparam int CNT_W        = 8;
  localparam int TOTAL_W      = 48;
  localparam int STEP_W       = 7;

  // iteration counts of the shared unit
  localparam int SQRT_STEPS  = 32;
  localparam int RECIP_STEPS = 2 * FRAC_BITS + 1;
  localparam int FDIV_STEPS  = 64;

  localparam logic [31:0] ONE_W  = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_AREA = 2'd0,
    MODE_INV  = 2'd1,
    MODE_DIST = 2'd2,
    MODE_MEAN = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_SUMS, ST_SQRT, ST_WSEL,
    ST_RECIP, ST_PROD, ST_ACC, ST_FIN, ST_FDIV, ST_OUT
  } state_t;

  // request to the shared divide / square root unit
  typedef struct packed {
    logic              start;
    logic              is_sqrt;
    logic [63:0]       num;
    logic [63:0]       den;
    logic [STEP_W-1:0] steps;
  } iter_req_t;

endpackage
`default_nettype wire

// ----- rtl/ctnwa_iter.sv -----
// shared restoring divide and square root unit, one bit per cycle
`default_nettype none
module ctnwa_iter (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ctnwa_pkg::iter_req_t req,
  output logic                      busy,
  output logic [63:0]               q
);

  logic [65:0] rem_r, rem_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] q_r, q_nxt;
  logic [63:0] den_r, den_nxt;
  logic        sqrt_r, sqrt_nxt;
  logic [ctnwa_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;

  logic [65:0] rs;
  logic [65:0] trial;
  logic [66:0] diff;
  logic        ge;

  // one trial subtract per cycle
  always_comb begin
    if (sqrt_r) begin
      rs    = {rem_r[63:0], acc_r[63:62]};
      trial = {q_r, 2'b01};
    end else begin
      rs    = {rem_r[64:0], acc_r[63]};
      trial = {2'b00, den_r};
    end
    diff = {1'b0, rs} - {1'b0, trial};
    ge   = ~diff[66];
  end

  // next state of the iteration
  always_comb begin
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    sqrt_nxt = sqrt_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      rem_nxt  = '0;
      acc_nxt  = req.num;
      q_nxt    = '0;
      den_nxt  = req.den;
      sqrt_nxt = req.is_sqrt;
      cnt_nxt  = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[65:0] : rs;
      acc_nxt  = sqrt_r ? {acc_r[61:0], 2'b00} : {acc_r[62:0], 1'b0};
      q_nxt    = {q_r[62:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != ctnwa_pkg::STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    den_r  <= den_nxt;
    sqrt_r <= sqrt_nxt;
  end

  assign busy = busy_r;
  assign q    = q_r;

endmodule
`default_nettype wire

// ----- rtl/cell_to_node_weighted_average.sv -----
// top level: weighted average of adjacent cell values onto one mesh node
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_ready  cell value, area, centroid, node, last flag
//  out_     output     out_valid/out_ready node value, zero weight flag
//  cfg_     input      cfg_wr_en          weight mode
//
// between one cell transfer and the next: mean mode skips the multiplier, area mode
// uses it, distance mode adds the 32-step square root, inverse distance also
// adds the 33-step reciprocal; a last cell adds the final division and the load
// of the output register. square root, reciprocal and division share one unit.
// rst_n is synchronous; a held result in the output register does not stop the
// next cell from being taken, only the next result waits for it.
`default_nettype none
module cell_to_node_weighted_average (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_cell_value,
  input  wire logic [31:0] in_cell_area,
  input  wire logic [31:0] in_cell_x,
  input  wire logic [31:0] in_cell_y,
  input  wire logic [31:0] in_node_x,
  input  wire logic [31:0] in_node_y,
  input  wire logic        in_last_cell,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_node_value,
  output logic             out_zero_weight
);

  ctnwa_pkg::state_t state_r, state_nxt;
  ctnwa_pkg::mode_t  mode_r;

  logic [63:0] sum_r, sum_nxt;
  logic [ctnwa_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [ctnwa_pkg::CNT_W-1:0]   count_r, count_nxt;

  logic [31:0] val_r, val_nxt;
  logic [32:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic        last_r, last_nxt;
  logic [31:0] w_r, w_nxt;
  logic [31:0] d_r, d_nxt;
  logic [63:0] a2_r, a2_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] res_val_r, res_val_nxt;
  logic        res_zero_r, res_zero_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_val_r, out_val_nxt;
  logic        out_zero_r, out_zero_nxt;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p, mul_r;

  ctnwa_pkg::iter_req_t req;
  logic        iter_busy;
  logic [63:0] iter_q;

  // signed coordinate differences, magnitude only
  logic signed [32:0] dx, dy;
  assign dx = $signed({in_node_x[31], in_node_x}) - $signed({in_cell_x[31], in_cell_x});
  assign dy = $signed({in_node_y[31], in_node_y}) - $signed({in_cell_y[31], in_cell_y});

  ctnwa_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .busy  (iter_busy),
    .q     (iter_q)
  );

  // shared multiplier, operands picked by state
  always_comb begin
    case (state_r)
      ctnwa_pkg::ST_SQX: begin
        mul_a = $signed({1'b0, ax_r});
        mul_b = $signed({1'b0, ax_r});
      end
      ctnwa_pkg::ST_PROD: begin
        mul_a = $signed({{2{val_r[31]}}, val_r});
        mul_b = $signed({2'b00, w_r});
      end
      default: begin
        mul_a = $signed({1'b0, ay_r});
        mul_b = $signed({1'b0, ay_r});
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // sequencer
  always_comb begin
    logic [64:0] s65;
    logic [63:0] p;
    logic [63:0] s;
    logic [ctnwa_pkg::TOTAL_W:0] t;
    logic [63:0] divisor;
    logic [63:0] qm;

    state_nxt    = state_r;
    sum_nxt      = sum_r;
    total_nxt    = total_r;
    count_nxt    = count_r;
    val_nxt      = val_r;
    ax_nxt       = ax_r;
    ay_nxt       = ay_r;
    last_nxt     = last_r;
    w_nxt        = w_r;
    d_nxt        = d_r;
    a2_nxt       = a2_r;
    neg_nxt      = neg_r;
    res_val_nxt  = res_val_r;
    res_zero_nxt = res_zero_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_zero_nxt  = out_zero_r;
    req          = '0;
    s65          = {1'b0, a2_r} + {1'b0, mul_r[63:0]};
    p            = '0;
    s            = '0;
    t            = '0;
    divisor      = (mode_r == ctnwa_pkg::MODE_MEAN) ?
                   {{(64 - ctnwa_pkg::CNT_W){1'b0}}, count_r} :
                   {{(64 - ctnwa_pkg::TOTAL_W){1'b0}}, total_r};
    qm           = iter_q;

    // output register drains independently
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ctnwa_pkg::ST_IDLE: begin
        if (in_valid) begin
          val_nxt  = in_cell_value;
          ax_nxt   = dx[32] ? 33'(-dx) : 33'(dx);
          ay_nxt   = dy[32] ? 33'(-dy) : 33'(dy);
          last_nxt = in_last_cell;
          if (count_r >= ctnwa_pkg::CNT_W'(ctnwa_pkg::MAX_ADJACENT)) begin
            state_nxt = ctnwa_pkg::ST_FIN;
          end else begin
            case (mode_r)
              ctnwa_pkg::MODE_AREA: begin
                w_nxt     = in_cell_area;
                state_nxt = ctnwa_pkg::ST_PROD;
              end
              ctnwa_pkg::MODE_MEAN: begin
                w_nxt     = ctnwa_pkg::ONE_W;
                state_nxt = ctnwa_pkg::ST_ACC;
              end
              default: state_nxt = ctnwa_pkg::ST_SQX;
            endcase
          end
        end
      end
      ctnwa_pkg::ST_SQX: state_nxt = ctnwa_pkg::ST_SQY;
      ctnwa_pkg::ST_SQY: begin
        a2_nxt    = mul_r[63:0];
        state_nxt = ctnwa_pkg::ST_SUMS;
      end
      // squares wrap at 64 bits; a carry out of their sum saturates the distance
      ctnwa_pkg::ST_SUMS: begin
        if (s65[64]) begin
          d_nxt     = ctnwa_pkg::MASK32;
          state_nxt = ctnwa_pkg::ST_WSEL;
        end else begin
          req.start   = 1'b1;
          req.is_sqrt = 1'b1;
          req.num     = s65[63:0];
          req.steps   = ctnwa_pkg::STEP_W'(ctnwa_pkg::SQRT_STEPS);
          state_nxt   = ctnwa_pkg::ST_SQRT;
        end
      end
      ctnwa_pkg::ST_SQRT: begin
        if (!iter_busy) begin
          d_nxt     = iter_q[31:0];
          state_nxt = ctnwa_pkg::ST_WSEL;
        end
      end
      ctnwa_pkg::ST_WSEL: begin
        if (mode_r == ctnwa_pkg::MODE_DIST) begin
          w_nxt     = d_r;
          state_nxt = ctnwa_pkg::ST_PROD;
        end else if (d_r == '0) begin
          w_nxt     = ctnwa_pkg::MASK32;
          state_nxt = ctnwa_pkg::ST_PROD;
        end else begin
          // 2^(2*frac) read msb first over the step count
          req.start = 1'b1;
          req.num   = 64'h8000_0000_0000_0000;
          req.den   = {32'd0, d_r};
          req.steps = ctnwa_pkg::STEP_W'(ctnwa_pkg::RECIP_STEPS);
          state_nxt = ctnwa_pkg::ST_RECIP;
        end
      end
      ctnwa_pkg::ST_RECIP: begin
        if (!iter_busy) begin
          w_nxt     = (|iter_q[63:32]) ? ctnwa_pkg::MASK32 : iter_q[31:0];
          state_nxt = ctnwa_pkg::ST_PROD;
        end
      end
      ctnwa_pkg::ST_PROD: state_nxt = ctnwa_pkg::ST_ACC;
      // saturating accumulate of sum and total; count increments
      ctnwa_pkg::ST_ACC: begin
        p = (mode_r == ctnwa_pkg::MODE_MEAN) ? {{32{val_r[31]}}, val_r} : mul_r[63:0];
        s = sum_r + p;
        if ((sum_r[63] == p[63]) && (s[63] != sum_r[63]))
          sum_nxt = p[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        else
          sum_nxt = s;
        t = {1'b0, total_r} + {{(ctnwa_pkg::TOTAL_W - 31){1'b0}}, w_r};
        total_nxt = t[ctnwa_pkg::TOTAL_W] ? '1 : t[ctnwa_pkg::TOTAL_W-1:0];
        count_nxt = count_r + 1'b1;
        state_nxt = ctnwa_pkg::ST_FIN;
      end
      ctnwa_pkg::ST_FIN: begin
        if (!last_r) begin
          state_nxt = ctnwa_pkg::ST_IDLE;
        end else begin
          sum_nxt   = '0;
          total_nxt = '0;
          count_nxt = '0;
          if (divisor == '0) begin
            res_val_nxt  = '0;
            res_zero_nxt = 1'b1;
            state_nxt    = ctnwa_pkg::ST_OUT;
          end else begin
            neg_nxt   = sum_r[63];
            req.start = 1'b1;
            req.num   = sum_r[63] ? 64'(-sum_r) : sum_r;
            req.den   = divisor;
            req.steps = ctnwa_pkg::STEP_W'(ctnwa_pkg::FDIV_STEPS);
            state_nxt = ctnwa_pkg::ST_FDIV;
          end
        end
      end
      // sign and saturate the quotient magnitude
      ctnwa_pkg::ST_FDIV: begin
        if (!iter_busy) begin
          res_zero_nxt = 1'b0;
          if (neg_r)
            res_val_nxt = (qm > 64'h8000_0000) ? 32'h8000_0000 : 32'(-qm);
          else
            res_val_nxt = (qm > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qm[31:0];
          state_nxt = ctnwa_pkg::ST_OUT;
        end
      end
      ctnwa_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_zero_nxt  = res_zero_r;
          state_nxt     = ctnwa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ctnwa_pkg::ST_IDLE;
    endcase
  end

  // state and accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctnwa_pkg::ST_IDLE;
      mode_r      <= ctnwa_pkg::MODE_AREA;
      sum_r       <= '0;
      total_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) mode_r <= ctnwa_pkg::mode_t'(cfg_wr_data);
      sum_r       <= sum_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mul_r      <= mul_p;
    val_r      <= val_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    last_r     <= last_nxt;
    w_r        <= w_nxt;
    d_r        <= d_nxt;
    a2_r       <= a2_nxt;
    neg_r      <= neg_nxt;
    res_val_r  <= res_val_nxt;
    res_zero_r <= res_zero_nxt;
    out_val_r  <= out_val_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign in_ready        = (state_r == ctnwa_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_node_value  = out_val_r;
  assign out_zero_weight = out_zero_r;

endmodule
`default_nettype wire

// ----- rtl/ctnwa_checker.sv -----
// port checker for the weighted average block, with its bind
`default_nettype none
`include "cell_to_node_weighted_average_defines.svh"
module ctnwa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_node_value,
  input wire logic        out_zero_weight
);

  // a held result keeps its payload
  `CTNWA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_node_value) && $stable(out_zero_weight))

  // zero divisor always reports a zero value
  `CTNWA_ASSERT_NOW(a_zero_value, clk, rst_n, out_valid && out_zero_weight, out_node_value == 32'd0)

  // a taken cell moves the sequencer out of idle, so no transfer right after one
  `CTNWA_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)

  // taking a cell while no result is shown does not itself raise a new result
  `CTNWA_ASSERT_NEXT(a_no_fast_out, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind cell_to_node_weighted_average ctnwa_checker u_ctnwa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_node_value  (out_node_value),
  .out_zero_weight (out_zero_weight)
);
`default_nettype wire
